[rtl/edc_pkg.sv]
// shared constants, types and tables for the epoch day date codec
`default_nettype none

package edc_pkg;

  // register stages in front of the output register
  localparam int NUM_STG = 9;

  typedef logic [NUM_STG:1] stage_vec_t;

  // absolute day number of 2009-10-31 on the march-based calendar
  localparam logic [32:0] EPOCH_ABS = 33'd734016;

  // ceil(2^31 / 100): product >> 31 is an exact quotient by 100 below 41 million
  localparam logic [24:0] RECIP_100 = 25'd21474837;

  // day offset of a march-based month, (m * 306 + 5) / 10
  function automatic logic [8:0] month_offset(input logic [3:0] mi);
    logic [8:0] off;
    case (mi)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

[rtl/edc_if.sv]
// request and response channel interfaces of the epoch day date codec
`default_nettype none

interface edc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [31:0] day_count;
  logic [15:0] header_word;
  logic [31:0] extended_days;

  modport source (
    output valid, func, year, month, day, day_count, header_word, extended_days,
    input  ready
  );
  modport sink (
    input  valid, func, year, month, day, day_count, header_word, extended_days,
    output ready
  );
endinterface

interface edc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] days;
  logic [23:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic        is_date;
  logic [6:0]  legacy_version;

  modport source (
    output valid, days, out_year, out_month, out_day, is_date, legacy_version,
    input  ready
  );
  modport sink (
    input  valid, days, out_year, out_month, out_day, is_date, legacy_version,
    output ready
  );
endinterface

`default_nettype wire

[rtl/edc_encode.sv]
// date to day count datapath, three working stages and an alignment delay line
`default_nettype none

module edc_encode import edc_pkg::*; (
  input  logic        clk,
  input  stage_vec_t  en,
  input  logic [13:0] year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  output logic [23:0] days
);

  localparam int WORK_STG = 3;
  localparam logic [23:0] ENC_BIAS = 24'(EPOCH_ABS + 33'd1);

  // stage 1: march-based month and year
  logic [4:0]  m9;
  logic [3:0]  mm;
  logic        dec;
  logic [13:0] s1_yy;
  logic [9:0]  s1_md;
  logic        s1_neg;

  always_comb begin
    m9 = 5'(month) + 5'd9;
    if (m9 >= 5'd24) begin
      mm = 4'(m9 - 5'd24);
    end else if (m9 >= 5'd12) begin
      mm = 4'(m9 - 5'd12);
    end else begin
      mm = 4'(m9);
    end
    dec = (mm >= 4'd10);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_yy  <= year - 14'(dec);
      s1_neg <= dec && (year == 14'd0);
      // day minus one is folded into the bias
      s1_md  <= 10'(month_offset(mm)) + 10'(day);
    end
  end

  // stage 2: products
  logic [38:0] s2_p100;
  logic [22:0] s2_y365;
  logic [13:0] s2_yy;
  logic [9:0]  s2_md;
  logic        s2_neg;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_p100 <= 39'(s1_yy) * 39'(RECIP_100);
      s2_y365 <= 23'(s1_yy) * 23'd365;
      s2_yy   <= s1_yy;
      s2_md   <= s1_md;
      s2_neg  <= s1_neg;
    end
  end

  // stage 3: day number and offset from the epoch, floored at zero
  logic [7:0]  q100;
  logic [23:0] sum;
  logic [23:0] dly [WORK_STG:NUM_STG];

  always_comb begin
    q100 = s2_p100[38:31];
    sum  = 24'(s2_y365) + 24'(s2_yy[13:2]) - 24'(q100) + 24'(q100[7:2]) + 24'(s2_md);
  end

  always_ff @(posedge clk) begin
    if (en[WORK_STG]) begin
      dly[WORK_STG] <= (s2_neg || sum < ENC_BIAS) ? 24'd0 : sum - ENC_BIAS;
    end
    for (int k = WORK_STG + 1; k <= NUM_STG; k++) begin
      if (en[k]) begin
        dly[k] <= dly[k-1];
      end
    end
  end

  assign days = dly[NUM_STG];

endmodule

`default_nettype wire

[rtl/edc_decode.sv]
// day count to date datapath, nine register stages
`default_nettype none

module edc_decode import edc_pkg::*; (
  input  logic        clk,
  input  stage_vec_t  en,
  input  logic [31:0] cnt,
  output logic [23:0] yr,
  output logic [3:0]  mon,
  output logic [4:0]  dom
);

  localparam logic [45:0] YR_DIV   = 46'd3652425;
  localparam logic [13:0] YR_SCALE = 14'd10000;
  localparam logic [45:0] YR_BIAS  = 46'd14780;
  // floor(2^48 / divisor), applied to the numerator shifted down by 16
  localparam logic [26:0] YR_RECIP = 27'((64'd1 << 48) / 64'(YR_DIV));

  // march-based month index of a day within the year
  function automatic logic [3:0] month_index(input logic [8:0] r);
    logic [15:0] t;
    logic [3:0]  mi;
    t  = 16'(r) * 16'd100 + 16'd52;
    mi = 4'd0;
    for (int k = 1; k <= 11; k++) begin
      if (t >= 16'(3060 * k)) begin
        mi = 4'(k);
      end
    end
    return mi;
  endfunction

  logic [32:0] s1_n;
  logic [45:0] s2_num;
  logic [32:0] s2_n;
  logic [55:0] s3_est;
  logic [45:0] s3_num;
  logic [32:0] s3_n;
  logic [23:0] s4_q0;
  logic [45:0] s4_prod;
  logic [45:0] s4_num;
  logic [32:0] s4_n;
  logic [23:0] s5_y;
  logic [32:0] s5_n;
  logic [48:0] s6_p100;
  logic [32:0] s6_y365;
  logic [23:0] s6_y;
  logic [32:0] s6_n;
  logic [32:0] s7_base;
  logic        s7_leap;
  logic [23:0] s7_y;
  logic [32:0] s7_n;
  logic [8:0]  s8_r;
  logic [23:0] s8_y;

  logic [45:0] rem;
  logic [16:0] q100;
  logic        div100;
  logic [33:0] diff;
  logic        neg;
  logic [3:0]  mi;

  always_comb begin
    rem    = s4_num - s4_prod;
    q100   = s6_p100[47:31];
    // low product bits stay below 2^24 exactly when the year is a multiple of 100
    div100 = (s6_p100[30:24] == 7'd0);
    diff   = {1'b0, s7_n} - {1'b0, s7_base};
    neg    = diff[33];
    mi     = month_index(s8_r);
  end

  always_ff @(posedge clk) begin
    // absolute day number
    if (en[1]) begin
      s1_n <= EPOCH_ABS + 33'(cnt);
    end
    // year estimate numerator
    if (en[2]) begin
      s2_num <= 46'(s1_n) * 46'(YR_SCALE) + YR_BIAS;
      s2_n   <= s1_n;
    end
    // reciprocal product, quotient low by at most one
    if (en[3]) begin
      s3_est <= 56'(s2_num[45:16]) * 56'(YR_RECIP);
      s3_num <= s2_num;
      s3_n   <= s2_n;
    end
    if (en[4]) begin
      s4_q0   <= s3_est[55:32];
      s4_prod <= 46'(s3_est[55:32]) * YR_DIV;
      s4_num  <= s3_num;
      s4_n    <= s3_n;
    end
    // quotient correction
    if (en[5]) begin
      s5_y <= s4_q0 + 24'(rem >= YR_DIV);
      s5_n <= s4_n;
    end
    if (en[6]) begin
      s6_p100 <= 49'(s5_y) * 49'(RECIP_100);
      s6_y365 <= 33'(s5_y) * 33'd365;
      s6_y    <= s5_y;
      s6_n    <= s5_n;
    end
    // day number of the year start and leap flag
    if (en[7]) begin
      s7_base <= s6_y365 + 33'(s6_y[23:2]) - 33'(q100) + 33'(q100[16:2]);
      s7_leap <= ((s6_y[1:0] == 2'd0) && !div100) || (div100 && q100[1:0] == 2'd0);
      s7_y    <= s6_y;
      s7_n    <= s6_n;
    end
    // step back one year when the estimate overshoots
    if (en[8]) begin
      s8_r <= neg ? diff[8:0] + 9'd365 + 9'(s7_leap) : diff[8:0];
      s8_y <= s7_y - 24'(neg);
    end
    if (en[9]) begin
      yr  <= s8_y + 24'(mi >= 4'd10);
      mon <= (mi < 4'd10) ? mi + 4'd3 : mi - 4'd9;
      dom <= 5'(s8_r - month_offset(mi) + 9'd1);
    end
  end

endmodule

`default_nettype wire

[rtl/epoch_day_date_codec.sv]
// top level of the epoch day date codec: handshake, stage control and result select
`default_nettype none

// Converts between Gregorian dates and a day count from the epoch 2009-10-31.
// func 0 encodes year, month and day to days since the epoch (0 for dates
// before it); func 1 decodes day_count to a date; func 2 reads the low 12
// bits of header_word: above 0x50 it is a date (value minus 0x50, or
// extended_days at 0xfff) with the year clamped to 2009..9999, otherwise
// is_date is 0 and legacy_version carries the value. func 3 gives an all-zero
// result, and fields an operation does not produce are 0. Every request beat
// gives exactly one response beat, in order. The block takes one beat per
// cycle while back-pressure has not filled it. Nine datapath stages, set by
// the decode chain (day count times 10000, reciprocal multiply for the year
// estimate, quotient correction, year start day number, leap step-back,
// month split), are followed by the output register. Each stage advances
// when it is empty or its successor advances, so bubbles close up under
// back-pressure and ready drops only when all ten stages hold results.
// The 14-bit year range fits the 24-bit day count of the encoder.

module epoch_day_date_codec import edc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  edc_req_if.sink      req,
  edc_rsp_if.source    rsp
);

  typedef enum logic [1:0] {
    FUNC_ENCODE = 2'd0,
    FUNC_DECODE = 2'd1,
    FUNC_HEADER = 2'd2
  } func_t;

  typedef struct packed {
    func_t      func;
    logic       hdr_date;
    logic [6:0] legacy;
  } ctl_t;

  localparam logic [11:0] HDR_LEGACY_MAX = 12'h050;
  localparam logic [11:0] HDR_EXTENDED   = 12'hfff;
  localparam logic [23:0] YEAR_MIN       = 24'd2009;
  localparam logic [23:0] YEAR_MAX       = 24'd9999;

  // stage control
  stage_vec_t vld;
  stage_vec_t vld_in;
  stage_vec_t en;
  logic       en_out;
  logic       rsp_valid;

  always_comb begin
    en_out       = !rsp_valid || rsp.ready;
    en[NUM_STG]  = !vld[NUM_STG] || en_out;
    for (int k = NUM_STG - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign vld_in    = {vld[NUM_STG-1:1], req.valid};
  assign req.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      vld <= (en & vld_in) | (~en & vld);
      if (en_out) begin
        rsp_valid <= vld[NUM_STG];
      end
    end
  end

  // request decode: pick the day count that feeds the shared decoder
  logic [11:0] hv;
  logic [31:0] cnt;
  ctl_t        ctl_in;

  always_comb begin
    hv              = req.header_word[11:0];
    ctl_in.func     = func_t'(req.func);
    ctl_in.hdr_date = (hv > HDR_LEGACY_MAX);
    ctl_in.legacy   = hv[6:0];
    if (ctl_in.func == FUNC_DECODE) begin
      cnt = req.day_count;
    end else if (hv == HDR_EXTENDED) begin
      cnt = req.extended_days;
    end else begin
      cnt = 32'(hv - HDR_LEGACY_MAX);
    end
  end

  // operation tags travel alongside the datapath
  ctl_t ctl [1:NUM_STG];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ctl[1] <= ctl_in;
    end
    for (int k = 2; k <= NUM_STG; k++) begin
      if (en[k]) begin
        ctl[k] <= ctl[k-1];
      end
    end
  end

  // datapaths
  logic [23:0] enc_days;
  logic [23:0] dec_yr;
  logic [3:0]  dec_mon;
  logic [4:0]  dec_dom;

  edc_encode u_encode (
    .clk   (clk),
    .en    (en),
    .year  (req.year),
    .month (req.month),
    .day   (req.day),
    .days  (enc_days)
  );

  edc_decode u_decode (
    .clk (clk),
    .en  (en),
    .cnt (cnt),
    .yr  (dec_yr),
    .mon (dec_mon),
    .dom (dec_dom)
  );

  // result select and clamping
  ctl_t        c;
  logic [31:0] days_next;
  logic [23:0] year_next;
  logic [3:0]  month_next;
  logic [4:0]  day_next;
  logic        is_date_next;
  logic [6:0]  legacy_next;

  always_comb begin
    c            = ctl[NUM_STG];
    days_next    = 32'd0;
    year_next    = 24'd0;
    month_next   = 4'd0;
    day_next     = 5'd0;
    is_date_next = 1'b0;
    legacy_next  = 7'd0;
    case (c.func)
      FUNC_ENCODE: begin
        days_next = 32'(enc_days);
      end
      FUNC_DECODE: begin
        year_next  = dec_yr;
        month_next = dec_mon;
        day_next   = dec_dom;
      end
      FUNC_HEADER: begin
        if (c.hdr_date) begin
          if (dec_yr < YEAR_MIN) begin
            year_next = YEAR_MIN;
          end else if (dec_yr > YEAR_MAX) begin
            year_next = YEAR_MAX;
          end else begin
            year_next = dec_yr;
          end
          if (dec_mon == 4'd0) begin
            month_next = 4'd1;
          end else if (dec_mon > 4'd12) begin
            month_next = 4'd12;
          end else begin
            month_next = dec_mon;
          end
          day_next     = (dec_dom == 5'd0) ? 5'd1 : dec_dom;
          is_date_next = 1'b1;
        end else begin
          legacy_next = c.legacy;
        end
      end
      default: begin
        days_next = 32'd0;
      end
    endcase
  end

  // output register
  logic [31:0] res_days;
  logic [23:0] res_year;
  logic [3:0]  res_month;
  logic [4:0]  res_day;
  logic        res_is_date;
  logic [6:0]  res_legacy;

  always_ff @(posedge clk) begin
    if (en_out) begin
      res_days    <= days_next;
      res_year    <= year_next;
      res_month   <= month_next;
      res_day     <= day_next;
      res_is_date <= is_date_next;
      res_legacy  <= legacy_next;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.days           = res_days;
  assign rsp.out_year       = res_year;
  assign rsp.out_month      = res_month;
  assign rsp.out_day        = res_day;
  assign rsp.is_date        = res_is_date;
  assign rsp.legacy_version = res_legacy;

endmodule

`default_nettype wire
